FILE: sv/mtep_pkg.sv
// Package with shared types, constants and codes for the MIDI track event parser.
`timescale 1ns / 1ps

package mtep_pkg;

   localparam int TimeWidthDefault = 32;
   localparam logic [14:0] FilePpqnReset = 15'd96;
   localparam logic [15:0] OutPpqnReset = 16'd192;

   // Register indexes of the configuration port.
   localparam logic CsrFilePpqn = 1'b0;
   localparam logic CsrOutPpqn  = 1'b1;

   // Result kinds.
   localparam logic [1:0] KindChannel = 2'd0;
   localparam logic [1:0] KindEnd     = 2'd1;
   localparam logic [1:0] KindBadSysex = 2'd2;
   localparam logic [1:0] KindEndOdd  = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       track_first;
      logic       track_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  status;
      logic [7:0]  data1;
      logic [6:0]  data2;
      logic [31:0] tick;
   } rsp_type;

   // Command from the controller to the scaling datapath.
   typedef struct packed {
      logic       start;
      logic [1:0] kind;
      logic [7:0] status;
      logic [7:0] data1;
      logic [6:0] data2;
   } mtep_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic busy;
   } mtep_sts_type;

endpackage

FILE: sv/mtep_scale.sv
// Datapath: multiplies the track time by out_ppqn and divides by file_ppqn bit-serially.
`timescale 1ns / 1ps

module mtep_scale #(
   parameter int TIME_WIDTH = mtep_pkg::TimeWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [TIME_WIDTH-1:0]         time_total,
   input  logic [14:0]                   file_ppqn,
   input  logic [15:0]                   out_ppqn,
   input  mtep_pkg::mtep_cmd_type        cmd,
   output mtep_pkg::mtep_sts_type        sts,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mtep_pkg::rsp_type             rsp_data
);
   import mtep_pkg::*;

   localparam int ProdWidth = TIME_WIDTH + 16;
   localparam int CntWidth = $clog2(ProdWidth + 2);
   localparam logic [CntWidth-1:0] LastBit = CntWidth'(ProdWidth - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [ProdWidth-1:0] prod_ff, prod_in;
   logic [15:0]          rem_ff, rem_in;
   logic [14:0]          div_ff, div_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   mtep_cmd_type         hold_ff, hold_in;
   logic [16:0]          trial;
   logic [15:0]          shifted;
   logic [ProdWidth-1:0] mul_a;

   assign mul_a = ProdWidth'(time_total);
   assign shifted = {rem_ff[14:0], prod_ff[ProdWidth-1]};
   assign trial = {1'b0, shifted} - {2'b00, div_ff};

   // Multiply, then one restoring-division step per cycle over the product bits, then hold the result until taken.
   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      hold_in  = hold_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               hold_in  = cmd;
               div_in   = (file_ppqn == 15'd0) ? 15'd1 : file_ppqn;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mul_a * ProdWidth'(out_ppqn);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial[16]) begin
               rem_in  = trial[15:0];
               prod_in = {prod_ff[ProdWidth-2:0], 1'b1};
            end else begin
               rem_in  = shifted;
               prod_in = {prod_ff[ProdWidth-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastBit) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      hold_ff <= hold_in;
   end

   assign sts.busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data.kind   = hold_ff.kind;
   assign rsp_data.status = hold_ff.status;
   assign rsp_data.data1  = hold_ff.data1;
   assign rsp_data.data2  = hold_ff.data2;
   assign rsp_data.tick   = prod_ff[31:0];

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == ST_IDLE) else $error("start while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_ff != 15'd0) else $error("zero divisor");
`endif

endmodule

FILE: sv/mtep_ctrl.sv
// Controller: byte parser state machine with running status, deltas and sysex handling.
`timescale 1ns / 1ps

module mtep_ctrl #(
   parameter int TIME_WIDTH = mtep_pkg::TimeWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mtep_pkg::req_type      req_data,
   input  mtep_pkg::mtep_sts_type sts,
   output mtep_pkg::mtep_cmd_type cmd,
   output logic [TIME_WIDTH-1:0]  time_total
);
   import mtep_pkg::*;

   typedef enum logic [3:0] {
      PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_ONE, PH_META_TYPE,
      PH_META_LEN, PH_META_END, PH_SYX_LEN, PH_SYX_BODY, PH_CUE_HI,
      PH_CUE_LO, PH_SKIP
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [7:0]            rs_ff, rs_in;
   logic [TIME_WIDTH-1:0] time_ff, time_in;
   logic [TIME_WIDTH-1:0] vlq_ff, vlq_in;
   logic [31:0]           rem_ff, rem_in;
   logic                  done_ff, done_in;
   logic [7:0]            held_ff [4];
   logic [7:0]            held0_in;
   logic [1:0]            body_ff, body_in;
   logic                  accept;
   logic [7:0]            b;
   logic [7:0]            st;
   logic [31:0]           len_next;
   phase_type             route_ph, eff_ph;
   mtep_cmd_type          cmd_in;

   // The time must stay put until the scaler has sampled it.
   assign req_stall = sts.busy || cmd.start;
   assign accept = req_valid && !req_stall;
   assign b = req_data.data_byte;
   assign time_total = time_ff;
   assign len_next = {rem_ff[24:0], b[6:0]};

   // Phase that a status byte leads to.
   always_comb begin
      priority if (st[7:4] == 4'h8 || st[7:4] == 4'h9 || st[7:4] == 4'hA ||
                   st[7:4] == 4'hB || st[7:4] == 4'hE) route_ph = PH_DATA1;
      else if (st[7:4] == 4'hC || st[7:4] == 4'hD) route_ph = PH_ONE;
      else if (st == 8'hFF) route_ph = PH_META_TYPE;
      else if (st == 8'hF0) route_ph = PH_SYX_LEN;
      else route_ph = PH_DELTA;
   end

   // Next-state logic for one accepted byte.
   always_comb begin
      logic [TIME_WIDTH-1:0] t0;
      logic [TIME_WIDTH-1:0] v0;
      logic [7:0]            rs0;
      phase_type             ph0;
      logic                  dn0;
      t0 = req_data.track_first ? '0 : time_ff;
      v0 = req_data.track_first ? '0 : vlq_ff;
      rs0 = req_data.track_first ? 8'hFF : rs_ff;
      ph0 = req_data.track_first ? PH_DELTA : phase_ff;
      dn0 = req_data.track_first ? 1'b0 : done_ff;
      phase_in = ph0;
      rs_in = rs0;
      time_in = t0;
      vlq_in = v0;
      rem_in = req_data.track_first ? '0 : rem_ff;
      done_in = dn0;
      held0_in = held_ff[0];
      body_in = body_ff;
      cmd_in = '0;
      st = (ph0 == PH_STATUS && b[7]) ? b : rs0;
      eff_ph = ph0;
      if (ph0 == PH_STATUS && !b[7]) begin
         eff_ph = route_ph;
         if (route_ph == PH_SYX_LEN) rem_in = '0;
      end
      if (!dn0) begin
         unique case (eff_ph)
            PH_DELTA: begin
               if (b[7]) begin
                  vlq_in = {v0[TIME_WIDTH-8:0], b[6:0]};
               end else begin
                  time_in = t0 + {v0[TIME_WIDTH-8:0], b[6:0]};
                  vlq_in = '0;
                  phase_in = PH_STATUS;
               end
            end
            PH_STATUS: begin
               rs_in = b;
               phase_in = route_ph;
               if (route_ph == PH_SYX_LEN) rem_in = '0;
            end
            PH_DATA1: begin
               held0_in = b;
               phase_in = PH_DATA2;
            end
            PH_DATA2: begin
               phase_in = PH_DELTA;
               cmd_in.start = 1'b1;
               cmd_in.kind = KindChannel;
               cmd_in.data1 = held_ff[0];
               if (rs0[7:4] == 4'h9 && b == 8'h00) begin
                  cmd_in.status = {4'h8, rs0[3:0]};
                  cmd_in.data2 = 7'd127;
               end else begin
                  cmd_in.status = rs0;
                  cmd_in.data2 = b[6:0];
               end
            end
            PH_ONE: begin
               phase_in = PH_DELTA;
               cmd_in.start = 1'b1;
               cmd_in.kind = KindChannel;
               cmd_in.status = rs0;
               cmd_in.data1 = b;
            end
            PH_META_TYPE: begin
               if (b == 8'h2F) begin
                  phase_in = PH_META_END;
               end else begin
                  rem_in = '0;
                  phase_in = PH_META_LEN;
               end
            end
            PH_META_LEN: begin
               rem_in = len_next;
               if (!b[7]) phase_in = (len_next != 32'd0) ? PH_SKIP : PH_DELTA;
            end
            PH_META_END: begin
               done_in = 1'b1;
               phase_in = PH_DELTA;
               cmd_in.start = 1'b1;
               cmd_in.kind = (b != 8'h00) ? KindEndOdd : KindEnd;
               cmd_in.status = 8'hFF;
            end
            PH_SYX_LEN: begin
               rem_in = len_next;
               if (!b[7]) begin
                  if (len_next < 32'd4) begin
                     phase_in = (len_next != 32'd0) ? PH_SKIP : PH_DELTA;
                     cmd_in.start = 1'b1;
                     cmd_in.kind = KindBadSysex;
                     cmd_in.status = 8'hF0;
                  end else begin
                     rem_in = len_next - 32'd4;
                     body_in = 2'd0;
                     phase_in = PH_SYX_BODY;
                  end
               end
            end
            PH_SYX_BODY: begin
               body_in = body_ff + 2'd1;
               if (body_ff == 2'd3) begin
                  if (held_ff[0] == 8'h7F && held_ff[2] == 8'h05) begin
                     if (b == 8'h05 || b == 8'h06) begin
                        phase_in = PH_CUE_HI;
                     end else begin
                        phase_in = (rem_ff != 32'd0) ? PH_SKIP : PH_DELTA;
                        cmd_in.start = 1'b1;
                        cmd_in.kind = KindBadSysex;
                        cmd_in.status = 8'hF0;
                     end
                  end else begin
                     phase_in = (rem_ff != 32'd0) ? PH_SKIP : PH_DELTA;
                  end
               end
            end
            PH_CUE_HI: phase_in = PH_CUE_LO;
            PH_CUE_LO: begin
               rem_in = (rem_ff >= 32'd2) ? rem_ff - 32'd2 : 32'd0;
               phase_in = (rem_ff > 32'd2) ? PH_SKIP : PH_DELTA;
               cmd_in.start = 1'b1;
               cmd_in.kind = KindChannel;
               cmd_in.status = (held_ff[3] == 8'h05) ? 8'h90 : 8'h80;
               cmd_in.data1 = b;
            end
            PH_SKIP: begin
               if (rem_ff != 32'd0) rem_in = rem_ff - 32'd1;
               if (rem_ff <= 32'd1) phase_in = PH_DELTA;
            end
            default: begin
               phase_in = PH_DELTA;
               vlq_in = '0;
            end
         endcase
      end
      if (req_data.track_last) begin
         phase_in = PH_DELTA;
         vlq_in = '0;
         rem_in = '0;
         done_in = 1'b1;
      end
   end

   // State register and held bytes.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA;
         rs_ff <= 8'hFF;
         time_ff <= '0;
         vlq_ff <= '0;
         rem_ff <= '0;
         done_ff <= 1'b0;
         body_ff <= '0;
         cmd <= '0;
      end else begin
         cmd <= '0;
         if (accept) begin
            phase_ff <= phase_in;
            rs_ff <= rs_in;
            time_ff <= time_in;
            vlq_ff <= vlq_in;
            rem_ff <= rem_in;
            done_ff <= done_in;
            body_ff <= body_in;
            cmd <= cmd_in;
         end
      end
      if (accept && !done_ff && !req_data.track_first) begin
         if (eff_ph == PH_DATA1) held_ff[0] <= held0_in;
         if (eff_ph == PH_SYX_BODY) held_ff[body_ff] <= b;
      end else if (accept && req_data.track_first && eff_ph == PH_DATA1) begin
         held_ff[0] <= held0_in;
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      sts.busy |-> !accept) else $error("byte taken while scaling");
   a_cmd_from_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> $past(accept)) else $error("spurious command");
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      accept && done_ff && !req_data.track_first |=> !cmd.start)
      else $error("event after end");
`endif

endmodule

FILE: sv/midi_track_event_parser_core.sv
// Top level of the MIDI track event parser: configuration registers, controller and scaler.
`timescale 1ns / 1ps

// Takes one byte of a track chunk per beat and returns channel, end-of-track and
// bad-sysex events with their time scaled to time*out_ppqn/file_ppqn. Bytes that
// cause no event are taken back to back; after a byte that causes an event the
// input stalls until the scaler is idle again: past the accept, the command
// register, the multiply state, TIME_WIDTH+16 steps of a bit-serial restoring
// divider over the product, and the output state. A stalled result holds the
// input longer, as it waits in the output register until taken. Registers:
// index 0 file_ppqn, index 1 out_ppqn.
module midi_track_event_parser_core #(
   parameter int TIME_WIDTH = mtep_pkg::TimeWidthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mtep_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mtep_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [15:0]       csr_data
);
   import mtep_pkg::*;

   logic [14:0]           file_ppqn_ff;
   logic [15:0]           out_ppqn_ff;
   logic [TIME_WIDTH-1:0] time_total;
   mtep_cmd_type          cmd;
   mtep_sts_type          sts;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         file_ppqn_ff <= FilePpqnReset;
         out_ppqn_ff <= OutPpqnReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrFilePpqn: file_ppqn_ff <= csr_data[14:0];
            CsrOutPpqn:  out_ppqn_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mtep_ctrl #(.TIME_WIDTH(TIME_WIDTH)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .sts(sts), .cmd(cmd), .time_total(time_total)
   );

   mtep_scale #(.TIME_WIDTH(TIME_WIDTH)) u_scale (
      .clock(clock), .reset(reset), .time_total(time_total),
      .file_ppqn(file_ppqn_ff), .out_ppqn(out_ppqn_ff), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

FILE: verif/midi_track_event_parser_core_test.sv
// Self-checking testbench for the MIDI track event parser core.
`timescale 1ns / 1ps

module midi_track_event_parser_core_test;
   import mtep_pkg::*;

   localparam int IdleLimit = 20000;
   localparam int SettleCycles = 80;

   typedef enum logic [3:0] {
      PhDelta, PhStatus, PhData1, PhData2, PhOne, PhMetaType, PhMetaLen,
      PhMetaEnd, PhSyxLen, PhSyxBody, PhCueHi, PhCueLo, PhSkip
   } parse_phase_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write;
   logic csr_index;
   logic [15:0] csr_data;

   midi_track_event_parser_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Stimulus and expectation stores.
   req_type pending_bytes[$];
   rsp_type expected_events[$];
   bit failed;
   bit req_taken;
   int idle_cycles;

   // Mirror of the parser state.
   logic [14:0] file_ppqn;
   logic [15:0] out_ppqn;
   parse_phase_type phase;
   logic [7:0] running_status;
   logic [31:0] time_total;
   logic [31:0] vlq_accum;
   logic [7:0] held [4];
   logic [31:0] remaining;
   bit done_flag;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Current time rescaled to internal ticks.
   function automatic logic [31:0] scaled_tick();
      logic [63:0] product;
      logic [63:0] divisor;
      product = {32'd0, time_total} * {48'd0, out_ppqn};
      divisor = (file_ppqn == 15'd0) ? 64'd1 : {49'd0, file_ppqn};
      return 32'(product / divisor);
   endfunction

   function automatic rsp_type make_event(logic [1:0] kind, logic [7:0] st, logic [7:0] d1,
                                          logic [6:0] d2);
      rsp_type r;
      r.kind = kind;
      r.status = st;
      r.data1 = d1;
      r.data2 = d2;
      r.tick = scaled_tick();
      return r;
   endfunction

   function automatic parse_phase_type route(logic [7:0] st);
      case (st[7:4])
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return PhData1;
         4'hC, 4'hD: return PhOne;
         default: begin
            if (st == 8'hFF) return PhMetaType;
            if (st == 8'hF0) begin
               remaining = 0;
               return PhSyxLen;
            end
            return PhDelta;
         end
      endcase
   endfunction

   function automatic parse_phase_type skip_or_delta();
      return (remaining != 0) ? PhSkip : PhDelta;
   endfunction

   // Parses one byte; returns 1 when it produces an event.
   function automatic bit parse_byte(logic [7:0] b, output rsp_type r);
      logic [7:0] st;
      logic [6:0] d2;
      r = '0;
      case (phase)
         PhDelta: begin
            vlq_accum = (vlq_accum << 7) | {25'd0, b[6:0]};
            if (!b[7]) begin
               time_total = time_total + vlq_accum;
               vlq_accum = 0;
               phase = PhStatus;
            end
            return 0;
         end
         PhStatus: begin
            if (b[7]) begin
               running_status = b;
               phase = route(b);
               return 0;
            end
            // Running status: reparse the byte as the first one after the status.
            phase = route(running_status);
            return parse_byte(b, r);
         end
         PhData1: begin
            held[0] = b;
            phase = PhData2;
            return 0;
         end
         PhData2: begin
            st = running_status;
            d2 = b[6:0];
            phase = PhDelta;
            if (st[7:4] == 4'h9 && b == 8'd0) begin
               st = {4'h8, st[3:0]};
               d2 = 7'd127;
            end
            r = make_event(KindChannel, st, held[0], d2);
            return 1;
         end
         PhOne: begin
            phase = PhDelta;
            r = make_event(KindChannel, running_status, b, 7'd0);
            return 1;
         end
         PhMetaType: begin
            if (b == 8'h2F) phase = PhMetaEnd;
            else begin
               remaining = 0;
               phase = PhMetaLen;
            end
            return 0;
         end
         PhMetaLen: begin
            remaining = (remaining << 7) | {25'd0, b[6:0]};
            if (!b[7]) phase = skip_or_delta();
            return 0;
         end
         PhMetaEnd: begin
            done_flag = 1;
            phase = PhDelta;
            r = make_event((b != 0) ? KindEndOdd : KindEnd, 8'hFF, 8'd0, 7'd0);
            return 1;
         end
         PhSyxLen: begin
            remaining = (remaining << 7) | {25'd0, b[6:0]};
            if (b[7]) return 0;
            if (remaining < 4) begin
               phase = skip_or_delta();
               r = make_event(KindBadSysex, 8'hF0, 8'd0, 7'd0);
               return 1;
            end
            remaining = remaining - 4;
            vlq_accum = 0;
            phase = PhSyxBody;
            return 0;
         end
         PhSyxBody: begin
            held[vlq_accum[1:0]] = b;
            vlq_accum = vlq_accum + 1;
            if (vlq_accum < 4) return 0;
            vlq_accum = 0;
            if (held[0] == 8'h7F && held[2] == 8'h05) begin
               if (held[3] == 8'h05 || held[3] == 8'h06) begin
                  phase = PhCueHi;
                  return 0;
               end
               phase = skip_or_delta();
               r = make_event(KindBadSysex, 8'hF0, 8'd0, 7'd0);
               return 1;
            end
            phase = skip_or_delta();
            return 0;
         end
         PhCueHi: begin
            vlq_accum = {24'd0, b};
            phase = PhCueLo;
            return 0;
         end
         PhCueLo: begin
            st = (held[3] == 8'h05) ? 8'h90 : 8'h80;
            remaining = (remaining >= 2) ? remaining - 2 : 0;
            vlq_accum = 0;
            phase = skip_or_delta();
            r = make_event(KindChannel, st, b, 7'd0);
            return 1;
         end
         PhSkip: begin
            if (remaining != 0) remaining = remaining - 1;
            if (remaining == 0) phase = PhDelta;
            return 0;
         end
         default: begin
            phase = PhDelta;
            vlq_accum = 0;
            return 0;
         end
      endcase
   endfunction

   // Applies one accepted beat to the mirror and queues its event, if any.
   task automatic predict_beat(req_type item);
      rsp_type r;
      bit has_event;
      has_event = 0;
      if (item.track_first) begin
         time_total = 0;
         running_status = 8'hFF;
         phase = PhDelta;
         vlq_accum = 0;
         remaining = 0;
         done_flag = 0;
      end
      if (!done_flag) has_event = parse_byte(item.data_byte, r);
      if (has_event) expected_events.insert(expected_events.size(), r);
      if (item.track_last) begin
         phase = PhDelta;
         vlq_accum = 0;
         remaining = 0;
         done_flag = 1;
      end
   endtask

   // Driver: sends queued beats in bursts with random gaps.
   int burst_left;
   int gap_left;
   always @(negedge clock) begin
      logic next_valid;
      req_type next_data;
      next_valid = req_valid;
      next_data = req_data;
      if (reset) begin
         next_valid = 0;
      end else if (!req_valid || req_taken) begin
         next_valid = 0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_bytes.size() > 0) begin
            next_data = pending_bytes.pop_front();
            next_valid = 1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 400 : $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end
         end
      end
      req_valid <= next_valid;
      req_data <= next_data;
   end

   // Receiver stall pattern: stretches of no, light or heavy back pressure.
   int stall_mode;
   int stall_span;
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_span = $urandom_range(20, 300);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         default: rsp_stall <= ($urandom_range(0, 9) < 8);
      endcase
   end

   // Monitor: predicts on accepted input beats and checks output beats.
   always @(posedge clock) begin
      rsp_type exp_event;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (req_valid && !req_stall) predict_beat(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected event %p", $time, rsp_data);
               failed = 1;
            end else begin
               exp_event = expected_events.pop_front();
               if (rsp_data.kind != exp_event.kind || rsp_data.status != exp_event.status ||
                   rsp_data.data1 != exp_event.data1 || rsp_data.data2 != exp_event.data2 ||
                   rsp_data.tick != exp_event.tick) begin
                  $display("%0t: event mismatch, expected %p, actual %p", $time, exp_event,
                           rsp_data);
                  failed = 1;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no beat on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_byte(logic [7:0] b, logic first = 0, logic last = 0);
      req_type item;
      item.data_byte = b;
      item.track_first = first;
      item.track_last = last;
      pending_bytes.insert(pending_bytes.size(), item);
   endtask

   // Variable-length quantity, most significant group first.
   task automatic add_vlq(logic [31:0] v, logic first = 0);
      int groups;
      groups = 1;
      while (groups < 5 && (v >> (7 * groups)) != 0) groups++;
      for (int g = groups - 1; g >= 0; g--)
         add_byte({(g != 0), 7'(v >> (7 * g))}, first && (g == groups - 1));
   endtask

   function automatic logic [31:0] random_delta();
      case ($urandom_range(0, 9))
         0, 1, 2: return 0;
         3, 4, 5, 6: return $urandom_range(1, 127);
         7: return $urandom_range(128, 16383);
         8: return $urandom_range(16384, 32'h0FFFFFFF);
         default: return $urandom;
      endcase
   endfunction

   // One random event body, with its status sometimes left to running status.
   task automatic add_event();
      int choice;
      int len;
      logic [7:0] st;
      choice = $urandom_range(0, 99);
      if (choice < 55) begin
         st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
         if ($urandom_range(0, 3) != 0) add_byte(st);
         add_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : {1'b0, 7'($urandom)});
         if (st[6:5] != 2'b10)
            add_byte(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
      end else if (choice < 70) begin
         if ($urandom_range(0, 5) != 0) add_byte(8'hFF);
         add_byte({1'b0, 7'($urandom)});
         len = $urandom_range(0, 5);
         add_vlq(len);
         for (int i = 0; i < len; i++) add_byte(8'($urandom));
      end else if (choice < 92) begin
         if ($urandom_range(0, 5) != 0) add_byte(8'hF0);
         case ($urandom_range(0, 3))
            0: len = $urandom_range(0, 3);
            1: len = $urandom_range(4, 7);
            default: len = $urandom_range(6, 10);
         endcase
         add_vlq(len);
         if ($urandom_range(0, 3) != 0 && len >= 4) begin
            add_byte(8'h7F);
            add_byte(8'($urandom));
            add_byte(8'h05);
            add_byte(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(5, 6)));
            add_byte(8'($urandom));
            add_byte(8'($urandom));
            for (int i = 6; i < len; i++) add_byte(8'($urandom));
         end else begin
            for (int i = 0; i < len; i++) add_byte(8'($urandom));
         end
      end else if (choice < 96) begin
         st = 8'($urandom_range(8'hF1, 8'hFE));
         add_byte(st);
      end else begin
         add_byte(8'($urandom));
      end
   endtask

   // A whole track, sometimes cut short or with trailing bytes after its end.
   task automatic add_track(int events);
      add_vlq(random_delta(), 1);
      add_event();
      for (int e = 1; e < events; e++) begin
         add_vlq(random_delta());
         add_event();
      end
      if ($urandom_range(0, 5) == 0) begin
         add_byte(8'($urandom), 0, 1);
         return;
      end
      add_vlq(random_delta());
      add_byte(8'hFF);
      add_byte(8'h2F);
      if ($urandom_range(0, 3) == 0) begin
         add_byte(8'($urandom_range(1, 255)));
         add_byte(8'($urandom), 0, 1);
      end else begin
         add_byte(8'h00, 0, 1);
      end
   endtask

   // Waits for all beats and events to drain, then for the core to go quiet.
   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [15:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == CsrFilePpqn) file_ppqn = value[14:0];
      else out_ppqn = value;
   endtask

   initial begin
      logic [14:0] fp [6];
      logic [15:0] op [6];
      failed = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = CsrFilePpqn;
      csr_data = '0;
      req_taken = 0;
      idle_cycles = 0;
      burst_left = 1;
      gap_left = 0;
      stall_mode = 0;
      stall_span = 0;
      file_ppqn = FilePpqnReset;
      out_ppqn = OutPpqnReset;
      phase = PhDelta;
      running_status = 8'hFF;
      time_total = 0;
      vlq_accum = 0;
      remaining = 0;
      done_flag = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: parsed after reset without a track start.
      add_byte(8'h00); add_byte(8'h90); add_byte(8'h3C); add_byte(8'h40);
      add_byte(8'h81); add_byte(8'h00); add_byte(8'h3C); add_byte(8'h00);
      add_byte(8'h00); add_byte(8'hC5); add_byte(8'hFF);
      add_byte(8'h00); add_byte(8'hF0); add_byte(8'h02); add_byte(8'h01); add_byte(8'h02);
      add_byte(8'h00); add_byte(8'hF0); add_byte(8'h06); add_byte(8'h7F); add_byte(8'h00);
      add_byte(8'h05); add_byte(8'h06); add_byte(8'hFF); add_byte(8'hFF);
      add_byte(8'h00); add_byte(8'hF0); add_byte(8'h04); add_byte(8'h7F); add_byte(8'h00);
      add_byte(8'h05); add_byte(8'h07);
      add_byte(8'h00); add_byte(8'hF3); add_byte(8'h00); add_byte(8'h42);
      add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h7F);
      add_byte(8'h00); add_byte(8'hFF); add_byte(8'h2F); add_byte(8'h00);
      add_byte(8'h90); add_byte(8'h12, 0, 1);
      wait_drained();

      // Random tracks over several scaling settings, extremes included.
      fp = '{15'd96, 15'd1, 15'd32767, 15'd1, 15'd32767, 15'd0};
      op = '{16'd192, 16'd1, 16'd65535, 16'd65535, 16'd1, 16'd0};
      for (int p = 0; p < 6; p++) begin
         if (p == 5) begin
            fp[p] = 15'($urandom_range(1, 32767));
            op[p] = 16'($urandom_range(1, 65535));
         end
         write_csr(CsrFilePpqn, {1'b0, fp[p]});
         write_csr(CsrOutPpqn, op[p]);
         while (pending_bytes.size() < 280) add_track($urandom_range(1, 12));
         wait_drained();
      end

      if (!failed) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
